// ----- src/touch_gesture_tracker_unit_macros.svh -----
// Assertion macros shared by the touch gesture tracker RTL
`ifndef TOUCH_GESTURE_TRACKER_UNIT_MACROS_SVH
`define TOUCH_GESTURE_TRACKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TGT_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("touch gesture tracker: implication check failed");
`define TGT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("touch gesture tracker: next-cycle check failed");
`else
`define TGT_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define TGT_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ----- src/tgt_pkg.sv -----
// Shared codes and constants of the touch gesture tracker
package tgt_pkg;

	localparam int TIME_BITS    = 32;
	localparam int KIND_BITS    = 2;
	localparam int DIR_BITS     = 2;
	localparam int MT_BITS      = 8;
	localparam int SD_BITS      = 10;
	localparam int CFG_IDX_BITS = 2;
	localparam int CNT_BITS     = 2;
	localparam int LIM_W        = 2 * (SD_BITS + 1);

	localparam logic [KIND_BITS-1:0] EV_DOWN  = 2'd0;
	localparam logic [KIND_BITS-1:0] EV_MOVE  = 2'd1;
	localparam logic [KIND_BITS-1:0] EV_UP    = 2'd2;
	localparam logic [KIND_BITS-1:0] EV_SWIPE = 2'd3;

	localparam logic [DIR_BITS-1:0] DIR_RIGHT = 2'd0;
	localparam logic [DIR_BITS-1:0] DIR_LEFT  = 2'd1;
	localparam logic [DIR_BITS-1:0] DIR_DOWN  = 2'd2;
	localparam logic [DIR_BITS-1:0] DIR_UP    = 2'd3;

	localparam logic [CFG_IDX_BITS-1:0] CFG_MOVE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SWIPE_DISTANCE = 2'd1;

	localparam logic [MT_BITS-1:0] MOVE_THRESHOLD_RST = 8'd5;
	localparam int                 SWIPE_DIST_RST     = 50;
	localparam logic [LIM_W-1:0]   LIM_SQ_RST         =
		LIM_W'((SWIPE_DIST_RST + 1) * (SWIPE_DIST_RST + 1));

endpackage

// ----- src/tgt_core.sv -----
// Stroke state and per-sample event decision of the touch gesture tracker
module tgt_core
	import tgt_pkg::*;
#(
	parameter int COORD_BITS = 10,
	parameter int RAW_BITS   = 12,
	localparam int RES_W     = 4 * COORD_BITS + 2 * RAW_BITS + 2 * TIME_BITS
		+ KIND_BITS + DIR_BITS + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic                  touched,
	input  logic [COORD_BITS-1:0] pos_x,
	input  logic [COORD_BITS-1:0] pos_y,
	input  logic [RAW_BITS-1:0]   raw_x_in,
	input  logic [RAW_BITS-1:0]   raw_y_in,
	input  logic [TIME_BITS-1:0]  now_ms,
	input  logic [MT_BITS-1:0]    move_threshold,
	input  logic [LIM_W-1:0]      lim_sq,
	output logic [RES_W-1:0]      res0,
	output logic [RES_W-1:0]      res1,
	output logic [CNT_BITS-1:0]   res_cnt
);

	localparam int SQ_W  = 2 * COORD_BITS;
	localparam int D2_W  = 2 * COORD_BITS + 1;
	localparam int CMP_W = (D2_W > LIM_W) ? D2_W : LIM_W;

	typedef struct packed {
		logic [KIND_BITS-1:0]  kind;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [RAW_BITS-1:0]   raw_x;
		logic [RAW_BITS-1:0]   raw_y;
		logic [TIME_BITS-1:0]  t;
		logic [DIR_BITS-1:0]   dir;
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [TIME_BITS-1:0]  dur;
		logic                  last;
	} res_t;

	logic                  active_q;
	logic [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic [COORD_BITS-1:0] begin_x_q, begin_y_q;
	logic [TIME_BITS-1:0]  begin_time_q;

	logic [COORD_BITS-1:0]   mx, my, adx, ady, thr;
	logic [2*COORD_BITS-1:0] sqx, sqy;
	logic [D2_W-1:0]         d2;
	logic                    moved, swipe;
	logic [DIR_BITS-1:0]     dir;
	res_t                    r0, r1;

	always_comb begin
		mx  = (pos_x >= prev_x_q) ? pos_x - prev_x_q : prev_x_q - pos_x;
		my  = (pos_y >= prev_y_q) ? pos_y - prev_y_q : prev_y_q - pos_y;
		thr = COORD_BITS'(move_threshold);
		moved = (mx > thr) || (my > thr);

		adx = (prev_x_q >= begin_x_q) ? prev_x_q - begin_x_q : begin_x_q - prev_x_q;
		ady = (prev_y_q >= begin_y_q) ? prev_y_q - begin_y_q : begin_y_q - prev_y_q;
		sqx = SQ_W'(adx) * SQ_W'(adx);
		sqy = SQ_W'(ady) * SQ_W'(ady);
		d2  = D2_W'(sqx) + D2_W'(sqy);
		swipe = CMP_W'(d2) >= CMP_W'(lim_sq);
		// a tie between axes counts as vertical
		if (adx > ady)
			dir = (prev_x_q > begin_x_q) ? DIR_RIGHT : DIR_LEFT;
		else
			dir = (prev_y_q > begin_y_q) ? DIR_DOWN : DIR_UP;

		r0         = '0;
		r0.x       = pos_x;
		r0.y       = pos_y;
		r0.raw_x   = raw_x_in;
		r0.raw_y   = raw_y_in;
		r0.t       = now_ms;
		r1         = '0;
		r1.kind    = EV_SWIPE;
		r1.x       = prev_x_q;
		r1.y       = prev_y_q;
		r1.t       = now_ms;
		r1.dir     = dir;
		r1.start_x = begin_x_q;
		r1.start_y = begin_y_q;
		r1.dur     = now_ms - begin_time_q;
		r1.last    = 1'b1;
		res_cnt    = '0;

		priority if (touched && !active_q) begin
			r0.kind = EV_DOWN;
			res_cnt = 2'd1;
		end else if (touched) begin
			r0.kind = EV_MOVE;
			res_cnt = moved ? 2'd1 : 2'd0;
		end else if (active_q) begin
			r0.kind  = EV_UP;
			r0.x     = prev_x_q;
			r0.y     = prev_y_q;
			r0.raw_x = '0;
			r0.raw_y = '0;
			res_cnt  = swipe ? 2'd2 : 2'd1;
		end else begin
			res_cnt = '0;
		end
		r0.last = (res_cnt == 2'd1);
	end

	assign res0 = r0;
	assign res1 = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			begin_x_q    <= '0;
			begin_y_q    <= '0;
			begin_time_q <= '0;
		end else if (fire) begin
			if (touched) begin
				if (!active_q) begin
					begin_x_q    <= pos_x;
					begin_y_q    <= pos_y;
					begin_time_q <= now_ms;
				end
				prev_x_q <= pos_x;
				prev_y_q <= pos_y;
				active_q <= 1'b1;
			end else begin
				active_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/touch_gesture_tracker_unit.sv -----
// Top level of the touch gesture tracker: input stage, registers, result queue
//
//   channel | signals                        | direction
//   --------+--------------------------------+----------
//   in      | in_valid/in_ready, sample      | sink
//   out     | out_valid/out_ready, event     | source
//   cfg     | cfg_valid/cfg_ready, idx, data | sink
//
// One sample per cycle while the queue has room; its events are decided in the
// input register and enter a two-entry queue when that register hands its sample on.
// An up event followed by a swipe leaves in turn through the one output port.
// Reset clears the stroke state and queue and restores threshold 5, distance 50.
// A release waits for an empty queue, a touched sample for a free slot; a
// stalled output fills the queue and the input register then holds one sample.
`include "touch_gesture_tracker_unit_macros.svh"
module touch_gesture_tracker_unit
	import tgt_pkg::*;
#(
	parameter int COORD_BITS = 10,
	parameter int RAW_BITS   = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    touched,
	input  logic [COORD_BITS-1:0]   pos_x,
	input  logic [COORD_BITS-1:0]   pos_y,
	input  logic [RAW_BITS-1:0]     raw_x_in,
	input  logic [RAW_BITS-1:0]     raw_y_in,
	input  logic [TIME_BITS-1:0]    now_ms,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [KIND_BITS-1:0]    event_kind,
	output logic [COORD_BITS-1:0]   event_x,
	output logic [COORD_BITS-1:0]   event_y,
	output logic [RAW_BITS-1:0]     event_raw_x,
	output logic [RAW_BITS-1:0]     event_raw_y,
	output logic [TIME_BITS-1:0]    event_time_ms,
	output logic [DIR_BITS-1:0]     swipe_direction,
	output logic [COORD_BITS-1:0]   swipe_start_x,
	output logic [COORD_BITS-1:0]   swipe_start_y,
	output logic [TIME_BITS-1:0]    swipe_duration_ms,
	output logic                    last,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [SD_BITS-1:0]      cfg_data
);

	localparam int RES_W = 4 * COORD_BITS + 2 * RAW_BITS + 2 * TIME_BITS
		+ KIND_BITS + DIR_BITS + 1;

	typedef struct packed {
		logic [KIND_BITS-1:0]  kind;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [RAW_BITS-1:0]   raw_x;
		logic [RAW_BITS-1:0]   raw_y;
		logic [TIME_BITS-1:0]  t;
		logic [DIR_BITS-1:0]   dir;
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [TIME_BITS-1:0]  dur;
		logic                  last;
	} res_t;

	// configuration
	logic [MT_BITS-1:0] move_threshold_q;
	logic [LIM_W-1:0]   lim_sq_q;
	logic [SD_BITS:0]   lim;

	assign cfg_ready = 1'b1;
	assign lim       = {1'b0, cfg_data} + {{SD_BITS{1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_threshold_q <= MOVE_THRESHOLD_RST;
			lim_sq_q         <= LIM_SQ_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MOVE_THRESHOLD: move_threshold_q <= cfg_data[MT_BITS-1:0];
				CFG_SWIPE_DISTANCE: lim_sq_q <= LIM_W'(lim) * LIM_W'(lim);
				default: ;
			endcase
		end
	end

	// input register
	logic                  valid_s1;
	logic                  touched_s1;
	logic [COORD_BITS-1:0] pos_x_s1, pos_y_s1;
	logic [RAW_BITS-1:0]   raw_x_s1, raw_y_s1;
	logic [TIME_BITS-1:0]  now_s1;
	logic                  s1_go;
	logic [CNT_BITS-1:0]   cnt_q;

	// a release may produce two events, so it waits for an empty queue
	assign s1_go    = valid_s1 && (touched_s1 ? (cnt_q <= 2'd1) : (cnt_q == 2'd0));
	assign in_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			touched_s1 <= touched;
			pos_x_s1   <= pos_x;
			pos_y_s1   <= pos_y;
			raw_x_s1   <= raw_x_in;
			raw_y_s1   <= raw_y_in;
			now_s1     <= now_ms;
		end
	end

	logic [RES_W-1:0]    res0_w, res1_w;
	logic [CNT_BITS-1:0] res_cnt;

	tgt_core #(
		.COORD_BITS (COORD_BITS),
		.RAW_BITS   (RAW_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (s1_go),
		.touched        (touched_s1),
		.pos_x          (pos_x_s1),
		.pos_y          (pos_y_s1),
		.raw_x_in       (raw_x_s1),
		.raw_y_in       (raw_y_s1),
		.now_ms         (now_s1),
		.move_threshold (move_threshold_q),
		.lim_sq         (lim_sq_q),
		.res0           (res0_w),
		.res1           (res1_w),
		.res_cnt        (res_cnt)
	);

	// result queue: slot0 is the head shown on the output
	res_t                slot0_q, slot1_q;
	res_t                slot0_d, slot1_d;
	logic [CNT_BITS-1:0] cnt_d, rem;
	logic                pop;
	logic [CNT_BITS-1:0] push;

	assign pop  = out_valid && out_ready;
	assign push = s1_go ? res_cnt : 2'd0;

	always_comb begin
		slot0_d = slot0_q;
		slot1_d = slot1_q;
		rem     = cnt_q;
		if (pop) begin
			slot0_d = slot1_q;
			rem     = cnt_q - 2'd1;
		end
		unique case (push)
			2'd1: begin
				if (rem == 2'd0)
					slot0_d = res_t'(res0_w);
				else
					slot1_d = res_t'(res0_w);
			end
			2'd2: begin
				slot0_d = res_t'(res0_w);
				slot1_d = res_t'(res1_w);
			end
			default: ;
		endcase
		cnt_d = rem + push;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else
			cnt_q <= cnt_d;
	end

	always_ff @(posedge clk) begin
		slot0_q <= slot0_d;
		slot1_q <= slot1_d;
	end

	assign out_valid         = (cnt_q != 2'd0);
	assign event_kind        = slot0_q.kind;
	assign event_x           = slot0_q.x;
	assign event_y           = slot0_q.y;
	assign event_raw_x       = slot0_q.raw_x;
	assign event_raw_y       = slot0_q.raw_y;
	assign event_time_ms     = slot0_q.t;
	assign swipe_direction   = slot0_q.dir;
	assign swipe_start_x     = slot0_q.start_x;
	assign swipe_start_y     = slot0_q.start_y;
	assign swipe_duration_ms = slot0_q.dur;
	assign last              = slot0_q.last;

	`TGT_ASSERT_IMPLIES(a_cnt_range, clk, arst_n, 1'b1, cnt_q != 2'd3)
	`TGT_ASSERT_IMPLIES(a_pair_into_empty, clk, arst_n,
		s1_go && (res_cnt == 2'd2), cnt_q == 2'd0)
	`TGT_ASSERT_IMPLIES(a_head_not_last, clk, arst_n,
		out_valid && !slot0_q.last, cnt_q == 2'd2)
	`TGT_ASSERT_NEXT(a_swipe_follows_up, clk, arst_n,
		pop && (event_kind == EV_UP) && !last, out_valid && (event_kind == EV_SWIPE))

endmodule
